### rtl/core/pib_pkg.sv
// ----------------------------------------------------------------------------
// pib_pkg: shared types and constants of the point-in-box occupancy marker
// Item and result payloads, item modes, register indexes and the control
// word that walks down the chain of box cells.
// ----------------------------------------------------------------------------
package pib_pkg;

	localparam int BOUNDS_PER_BOX = 6;
	localparam int HIT_BOX_W      = 4;
	localparam int BITMAP_W       = 16;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 32;

	localparam logic [1:0] MODE_LOAD     = 2'd0;
	localparam logic [1:0] MODE_CLASSIFY = 2'd1;
	localparam logic [1:0] MODE_CLEAR    = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_BOX_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_MASK = 2'd1;

	typedef struct packed {
		logic [1:0]         mode;
		logic [3:0]         box_index;
		logic [2:0]         bound_index;
		logic signed [31:0] bound_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [31:0]        particle_flags;
	} item_t;

	typedef struct packed {
		logic [BITMAP_W-1:0]  occupied_boxes;
		logic                 hit;
		logic [HIT_BOX_W-1:0] hit_box;
	} result_t;

	// Bound write request broadcast to every cell.
	typedef struct packed {
		logic       we;
		logic [3:0] box_index;
		logic [2:0] bound_index;
	} bound_wr_t;

	// Control word of the particle that travels from cell to cell.
	typedef struct packed {
		logic                 valid;
		logic                 found;
		logic [HIT_BOX_W-1:0] hit_box;
	} tok_ctrl_t;

endpackage

### rtl/core/pib_cell.sv
// ----------------------------------------------------------------------------
// pib_cell: one box of the occupancy chain
// Holds the six bounds and the occupancy mark of one box, tests the passing
// particle against the box and hands the particle on to the next cell.
// ----------------------------------------------------------------------------
module pib_cell #(
	parameter int COORD_BITS = 32,
	parameter int CELL_IDX   = 0,
	parameter int CNT_W      = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pib_pkg::bound_wr_t           wr,
	input  logic signed [COORD_BITS-1:0] wr_value,
	input  logic                         clear,
	input  logic [CNT_W-1:0]             box_total,
	input  pib_pkg::tok_ctrl_t           ctrl_in,
	input  logic signed [COORD_BITS-1:0] x_in,
	input  logic signed [COORD_BITS-1:0] y_in,
	input  logic signed [COORD_BITS-1:0] z_in,
	output pib_pkg::tok_ctrl_t           ctrl_out,
	output logic signed [COORD_BITS-1:0] x_out,
	output logic signed [COORD_BITS-1:0] y_out,
	output logic signed [COORD_BITS-1:0] z_out,
	output logic                         mark
);

	logic signed [COORD_BITS-1:0] bound_q [pib_pkg::BOUNDS_PER_BOX];
	logic                         mark_q;
	pib_pkg::tok_ctrl_t           ctrl_s1;
	logic signed [COORD_BITS-1:0] x_s1;
	logic signed [COORD_BITS-1:0] y_s1;
	logic signed [COORD_BITS-1:0] z_s1;

	logic wr_hit;
	logic active;
	logic holds;
	logic take;

	assign wr_hit = wr.we && (int'(wr.box_index) == CELL_IDX)
		&& (int'(wr.bound_index) < pib_pkg::BOUNDS_PER_BOX);

	// Only boxes below the saturated box count take part in the search.
	assign active = int'(box_total) > CELL_IDX;

	// Minimum bounds are inclusive, maximum bounds exclusive.
	assign holds = (x_in >= bound_q[0]) && (x_in < bound_q[1])
		&& (y_in >= bound_q[2]) && (y_in < bound_q[3])
		&& (z_in >= bound_q[4]) && (z_in < bound_q[5]);

	assign take = ctrl_in.valid && !ctrl_in.found && active && holds;

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			bound_q[wr.bound_index] <= wr_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q  <= 1'b0;
			ctrl_s1 <= '0;
		end else begin
			if (clear) begin
				mark_q <= 1'b0;
			end else if (take) begin
				mark_q <= 1'b1;
			end
			ctrl_s1.valid <= ctrl_in.valid;
			if (take) begin
				ctrl_s1.found   <= 1'b1;
				ctrl_s1.hit_box <= pib_pkg::HIT_BOX_W'(CELL_IDX);
			end else begin
				ctrl_s1.found   <= ctrl_in.found;
				ctrl_s1.hit_box <= ctrl_in.hit_box;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x_in;
		y_s1 <= y_in;
		z_s1 <= z_in;
	end

	assign ctrl_out = ctrl_s1;
	assign x_out    = x_s1;
	assign y_out    = y_s1;
	assign z_out    = z_s1;
	assign mark     = mark_q;

endmodule

### rtl/core/point_in_box_occupancy_marker.sv
// ----------------------------------------------------------------------------
// point_in_box_occupancy_marker: first-hit box classification of particles
// A chain of box cells holds the box table and the occupancy marks. A
// particle walks the chain one cell per cycle and marks the first box
// that holds it.
// ----------------------------------------------------------------------------
//
//   channel   signals                           direction   payload
//   item      item_valid, item_ready, item      in          pib_pkg::item_t
//   result    result_valid, result_ready, result out       pib_pkg::result_t
//   cfg       cfg_we, cfg_index, cfg_wdata      in          32-bit register data
//
// A particle transaction steps from acceptance to its result through one
// box cell per cycle down the whole chain.
// Load, clear, reserved and skipped items give their result the cycle after
// acceptance. One item is in flight at a time.
// Reset clears the marks and the registers; box bounds are undefined until
// loaded and need no clearing pass.
// A stalled result holds the block until it is taken.
// ----------------------------------------------------------------------------
module point_in_box_occupancy_marker #(
	parameter int MAX_BOXES  = 16,
	parameter int COORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  pib_pkg::item_t                      item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output pib_pkg::result_t                    result,
	input  logic                                cfg_we,
	input  logic [pib_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [pib_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_BOXES + 1);

	logic [4:0]  box_count_q;
	logic [31:0] skip_mask_q;
	logic        busy_q;
	logic        result_valid_q;
	pib_pkg::result_t result_q;

	logic accept;
	logic is_load;
	logic is_clear;
	logic start;
	logic immediate;
	logic tok_exit;
	logic [CNT_W-1:0] box_total;
	pib_pkg::bound_wr_t wr;
	logic signed [COORD_BITS-1:0] wr_value;

	pib_pkg::tok_ctrl_t           ctrl [MAX_BOXES+1];
	logic signed [COORD_BITS-1:0] cx   [MAX_BOXES+1];
	logic signed [COORD_BITS-1:0] cy   [MAX_BOXES+1];
	logic signed [COORD_BITS-1:0] cz   [MAX_BOXES+1];
	logic [MAX_BOXES-1:0]         marks;
	logic [MAX_BOXES-1:0]         tok_valid;
	logic [MAX_BOXES+pib_pkg::BITMAP_W-1:0] marks_pad;
	logic [pib_pkg::BITMAP_W-1:0] bitmap;

	assign item_ready = !busy_q && (!result_valid_q || result_ready);
	assign accept     = item_valid && item_ready;

	always_comb begin
		is_load  = 1'b0;
		is_clear = 1'b0;
		start    = 1'b0;
		unique case (item.mode)
			pib_pkg::MODE_LOAD:     is_load  = accept;
			pib_pkg::MODE_CLASSIFY: start    = accept && ((item.particle_flags & skip_mask_q) == '0);
			pib_pkg::MODE_CLEAR:    is_clear = accept;
			default: ;
		endcase
	end

	assign immediate = accept && !start;
	assign tok_exit  = ctrl[MAX_BOXES].valid;

	// Box counts beyond the table size saturate.
	assign box_total = (int'(box_count_q) > MAX_BOXES) ? CNT_W'(MAX_BOXES) : CNT_W'(box_count_q);

	assign wr.we          = is_load;
	assign wr.box_index   = item.box_index;
	assign wr.bound_index = item.bound_index;
	assign wr_value       = COORD_BITS'($signed(item.bound_value));

	assign ctrl[0].valid   = start;
	assign ctrl[0].found   = 1'b0;
	assign ctrl[0].hit_box = '0;
	assign cx[0] = COORD_BITS'($signed(item.pos_x));
	assign cy[0] = COORD_BITS'($signed(item.pos_y));
	assign cz[0] = COORD_BITS'($signed(item.pos_z));

	for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
		pib_cell #(
			.COORD_BITS(COORD_BITS),
			.CELL_IDX  (i),
			.CNT_W     (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr       (wr),
			.wr_value (wr_value),
			.clear    (is_clear),
			.box_total(box_total),
			.ctrl_in  (ctrl[i]),
			.x_in     (cx[i]),
			.y_in     (cy[i]),
			.z_in     (cz[i]),
			.ctrl_out (ctrl[i+1]),
			.x_out    (cx[i+1]),
			.y_out    (cy[i+1]),
			.z_out    (cz[i+1]),
			.mark     (marks[i])
		);
		assign tok_valid[i] = ctrl[i+1].valid;
	end

	assign marks_pad = {{pib_pkg::BITMAP_W{1'b0}}, marks};
	assign bitmap    = marks_pad[pib_pkg::BITMAP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_count_q <= '0;
			skip_mask_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pib_pkg::CFG_BOX_COUNT: box_count_q <= cfg_wdata[4:0];
				pib_pkg::CFG_SKIP_MASK: skip_mask_q <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (tok_exit) begin
				busy_q <= 1'b0;
			end
			if (immediate || tok_exit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// The marks are already updated when the particle leaves the last cell.
	always_ff @(posedge clk) begin
		if (immediate) begin
			result_q.occupied_boxes <= is_clear ? '0 : bitmap;
			result_q.hit            <= 1'b0;
			result_q.hit_box        <= '0;
		end else if (tok_exit) begin
			result_q.occupied_boxes <= bitmap;
			result_q.hit            <= ctrl[MAX_BOXES].found;
			result_q.hit_box        <= ctrl[MAX_BOXES].hit_box;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_single_particle: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid))
		else $error("more than one particle in the cell chain");

	a_exit_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tok_exit |-> busy_q)
		else $error("particle left the chain while the block was not busy");

	a_clear_marks: assert property (@(posedge clk) disable iff (!arst_n)
		is_clear |=> (marks == '0))
		else $error("occupancy marks not cleared by a clear transaction");

	a_hit_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.hit) |->
			((MAX_BOXES > pib_pkg::BITMAP_W) || result.occupied_boxes[result.hit_box]))
		else $error("hit box is not marked in the occupancy bitmap");

endmodule
